[rtl/lcb_pkg.sv]
package lcb_pkg;

	// request kinds
	typedef enum logic [2:0] {
		ACT_TICK     = 3'd0,
		ACT_SET_MODE = 3'd1,
		ACT_SET_ALT  = 3'd2,
		ACT_VOTE     = 3'd3,
		ACT_RESOLVE  = 3'd4
	} action_t;

	// channel modes, pair membership is internal only
	typedef enum logic [2:0] {
		MODE_OFF  = 3'd0,
		MODE_ON   = 3'd1,
		MODE_FAST = 3'd2,
		MODE_SLOW = 3'd3,
		MODE_PAIR = 3'd4
	} mode_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_FAST   = 2'd0,
		CFG_SLOW   = 2'd1,
		CFG_ON_CHK = 2'd2,
		CFG_ALT    = 2'd3
	} cfg_idx_t;

	localparam logic [1:0]  NO_ERROR   = 2'd2;
	localparam logic [1:0]  ERR_CRIT   = 2'd0;
	localparam logic [31:0] FOREVER    = 32'hFFFF_FFFF;
	localparam logic [7:0]  VOTE_MAX   = 8'hFF;
	localparam logic [15:0] FAST_RESET = 16'd100;
	localparam logic [15:0] SLOW_RESET = 16'd500;
	localparam logic [15:0] ON_RESET   = 16'd100;
	localparam logic [15:0] ALT_RESET  = 16'd500;

	typedef struct packed {
		logic [15:0] fast_half;
		logic [15:0] slow_half;
		logic [15:0] on_check;
		logic [15:0] alt_half;
	} cfg_t;

	typedef struct packed {
		action_t     action;
		logic [1:0]  channel;
		logic [1:0]  partner;
		logic [1:0]  mode;
		logic [31:0] duration_ms;
		logic        error_type;
	} item_t;

	typedef struct packed {
		logic [3:0] led_levels;
		logic       alternate_active;
		logic [1:0] channel_error;
	} result_t;

	// a zero period acts as one
	function automatic logic [15:0] nz(input logic [15:0] p);
		return (p == 16'd0) ? 16'd1 : p;
	endfunction

	// reload value for a mode, zero stops the countdown
	function automatic logic [15:0] mode_period(input mode_t m, input cfg_t cfg);
		logic [15:0] p;
		case (m)
			MODE_ON:   p = nz(cfg.on_check);
			MODE_FAST: p = nz(cfg.fast_half);
			MODE_SLOW: p = nz(cfg.slow_half);
			default:   p = 16'd0;
		endcase
		return p;
	endfunction

endpackage

[rtl/lcb_core.sv]
module lcb_core #(
	parameter int CHANNELS    = 4,
	parameter int ERROR_KINDS = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  lcb_pkg::item_t  item,
	input  lcb_pkg::cfg_t   cfg,
	output lcb_pkg::result_t result
);
	import lcb_pkg::*;

	mode_t       mode_q   [CHANNELS];
	logic        level_q  [CHANNELS];
	logic [15:0] cd_q     [CHANNELS];
	logic [31:0] el_q     [CHANNELS];
	logic [31:0] dur_q    [CHANNELS];
	logic [1:0]  aerr_q   [CHANNELS];
	logic [7:0]  votes_q  [CHANNELS][ERROR_KINDS];
	logic [1:0]  pfirst_q, psecond_q;
	logic        pphase_q, prun_q;
	logic [15:0] pcd_q;

	mode_t       n_mode   [CHANNELS];
	logic        n_level  [CHANNELS];
	logic [15:0] n_cd     [CHANNELS];
	logic [31:0] n_el     [CHANNELS];
	logic [31:0] n_dur    [CHANNELS];
	logic [1:0]  n_aerr   [CHANNELS];
	logic [7:0]  n_votes  [CHANNELS][ERROR_KINDS];
	logic [1:0]  n_pfirst, n_psecond;
	logic        n_pphase, n_prun;
	logic [15:0] n_pcd;

	// next state for the registered item
	always_comb begin
		logic  ch_ok, pt_ok, a_pair, b_pair, ch_pair, ch_err, expired, eval, found;
		mode_t new_mode;
		logic [1:0] now;
		logic [7:0] v;
		n_mode    = mode_q;
		n_level   = level_q;
		n_cd      = cd_q;
		n_el      = el_q;
		n_dur     = dur_q;
		n_aerr    = aerr_q;
		n_votes   = votes_q;
		n_pfirst  = pfirst_q;
		n_psecond = psecond_q;
		n_pphase  = pphase_q;
		n_prun    = prun_q;
		n_pcd     = pcd_q;
		ch_ok     = int'(item.channel) < CHANNELS;
		pt_ok     = int'(item.partner) < CHANNELS;
		new_mode  = mode_t'({1'b0, item.mode});
		a_pair    = 1'b0;
		b_pair    = 1'b0;
		ch_err    = 1'b0;
		expired   = 1'b0;
		eval      = 1'b0;
		found     = 1'b0;
		now       = NO_ERROR;
		v         = 8'd0;
		for (int c = 0; c < CHANNELS; c++) begin
			if (int'(item.channel) == c) begin
				a_pair = (mode_q[c] == MODE_PAIR);
				ch_err = (aerr_q[c] != NO_ERROR);
			end
			if (int'(item.partner) == c) begin
				b_pair = (mode_q[c] == MODE_PAIR);
			end
		end
		ch_pair = a_pair;

		case (item.action)
			// one millisecond: every channel, then the pair
			ACT_TICK: begin
				for (int c = 0; c < CHANNELS; c++) begin
					if (el_q[c] != FOREVER) begin
						n_el[c] = el_q[c] + 32'd1;
					end
					if (cd_q[c] != 16'd0) begin
						n_cd[c] = cd_q[c] - 16'd1;
						if (cd_q[c] == 16'd1) begin
							expired = (dur_q[c] != FOREVER) && (n_el[c] >= dur_q[c]);
							if (aerr_q[c] != NO_ERROR) begin
								n_level[c] = ~level_q[c];
								n_cd[c]    = mode_period(mode_q[c], cfg);
							end else if (expired) begin
								n_cd[c]    = 16'd0;
								n_level[c] = 1'b0;
								n_mode[c]  = MODE_OFF;
							end else begin
								if (mode_q[c] == MODE_FAST || mode_q[c] == MODE_SLOW) begin
									n_level[c] = ~level_q[c];
								end
								n_cd[c] = mode_period(mode_q[c], cfg);
							end
						end
					end
				end
				if (prun_q && pcd_q != 16'd0) begin
					n_pcd = pcd_q - 16'd1;
					if (pcd_q == 16'd1) begin
						n_pphase = ~pphase_q;
						for (int c = 0; c < CHANNELS; c++) begin
							if (int'(pfirst_q) == c) begin
								n_level[c] = ~pphase_q;
							end
							if (int'(psecond_q) == c) begin
								n_level[c] = pphase_q;
							end
						end
						n_pcd = nz(cfg.alt_half);
					end
				end
			end

			// mode change, breaks the pair if the channel is in it
			ACT_SET_MODE: begin
				if (ch_ok) begin
					if (ch_pair) begin
						n_prun = 1'b0;
						n_pcd  = 16'd0;
					end
					for (int c = 0; c < CHANNELS; c++) begin
						if (ch_pair && (int'(pfirst_q) == c || int'(psecond_q) == c
								|| int'(item.channel) == c)) begin
							n_mode[c]  = MODE_OFF;
							n_level[c] = 1'b0;
						end
						if (int'(item.channel) == c && !ch_err) begin
							n_mode[c] = new_mode;
							if (new_mode == MODE_OFF) begin
								n_cd[c]    = 16'd0;
								n_level[c] = 1'b0;
							end else begin
								n_dur[c] = item.duration_ms;
								n_el[c]  = 32'd0;
								n_cd[c]  = mode_period(new_mode, cfg);
								if (new_mode == MODE_ON) begin
									n_level[c] = 1'b1;
								end
							end
						end
					end
				end
			end

			// new alternating pair
			ACT_SET_ALT: begin
				if (ch_ok && pt_ok && item.channel != item.partner && !(a_pair && b_pair)) begin
					for (int c = 0; c < CHANNELS; c++) begin
						if (prun_q && (int'(pfirst_q) == c || int'(psecond_q) == c)
								&& int'(item.channel) != c && int'(item.partner) != c
								&& mode_q[c] == MODE_PAIR) begin
							n_mode[c]  = MODE_OFF;
							n_level[c] = 1'b0;
						end
						if (int'(item.channel) == c) begin
							n_mode[c]  = MODE_PAIR;
							n_cd[c]    = 16'd0;
							n_level[c] = 1'b1;
						end
						if (int'(item.partner) == c) begin
							n_mode[c]  = MODE_PAIR;
							n_cd[c]    = 16'd0;
							n_level[c] = 1'b0;
						end
					end
					n_pfirst  = item.channel;
					n_psecond = item.partner;
					n_pphase  = 1'b1;
					n_prun    = 1'b1;
					n_pcd     = nz(cfg.alt_half);
				end
			end

			// vote or resolve, re-evaluate on a change to or from zero
			ACT_VOTE, ACT_RESOLVE: begin
				if (ch_ok) begin
					for (int c = 0; c < CHANNELS; c++) begin
						if (int'(item.channel) == c) begin
							for (int k = 0; k < ERROR_KINDS; k++) begin
								if (int'(item.error_type) == k) begin
									v = votes_q[c][k];
									if (item.action == ACT_VOTE) begin
										if (v != VOTE_MAX) begin
											n_votes[c][k] = v + 8'd1;
											eval = (v == 8'd0);
										end
									end else if (v != 8'd0) begin
										n_votes[c][k] = v - 8'd1;
										eval = (v == 8'd1);
									end
								end
							end
							for (int k = 0; k < ERROR_KINDS; k++) begin
								if (k < 2 && !found && n_votes[c][k] != 8'd0) begin
									now   = 2'(k);
									found = 1'b1;
								end
							end
							if (eval && now != aerr_q[c]) begin
								n_cd[c] = 16'd0;
								if (now != NO_ERROR) begin
									n_aerr[c] = now;
									n_mode[c] = (now == ERR_CRIT) ? MODE_FAST : MODE_SLOW;
									n_cd[c]   = mode_period(n_mode[c], cfg);
								end else begin
									n_aerr[c] = NO_ERROR;
									if (dur_q[c] != 32'd0) begin
										n_el[c] = 32'd0;
										n_cd[c] = mode_period(mode_q[c], cfg);
									end else begin
										n_level[c] = 1'b0;
									end
								end
							end
						end
					end
				end
			end

			default: begin
			end
		endcase
	end

	// result from the updated state
	always_comb begin
		result = '0;
		result.alternate_active = n_prun;
		result.channel_error    = NO_ERROR;
		for (int c = 0; c < CHANNELS; c++) begin
			if (c < 4) begin
				result.led_levels[c] = n_level[c];
			end
			if (int'(item.channel) == c) begin
				result.channel_error = n_aerr[c];
			end
		end
	end

	// channel and pair state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				mode_q[c]  <= MODE_OFF;
				level_q[c] <= 1'b0;
				cd_q[c]    <= 16'd0;
				el_q[c]    <= 32'd0;
				dur_q[c]   <= 32'd0;
				aerr_q[c]  <= NO_ERROR;
				for (int k = 0; k < ERROR_KINDS; k++) begin
					votes_q[c][k] <= 8'd0;
				end
			end
			pfirst_q  <= 2'd0;
			psecond_q <= 2'd0;
			pphase_q  <= 1'b0;
			prun_q    <= 1'b0;
			pcd_q     <= 16'd0;
		end else if (go) begin
			mode_q    <= n_mode;
			level_q   <= n_level;
			cd_q      <= n_cd;
			el_q      <= n_el;
			dur_q     <= n_dur;
			aerr_q    <= n_aerr;
			votes_q   <= n_votes;
			pfirst_q  <= n_pfirst;
			psecond_q <= n_psecond;
			pphase_q  <= n_pphase;
			prun_q    <= n_prun;
			pcd_q     <= n_pcd;
		end
	end

endmodule

[rtl/led_channel_blink_controller_unit.sv]
// channel   direction  signals                       request
// s         in         s_tvalid s_tready s_tdata s_tuser  one tick or command
// m         out        m_tvalid m_tready m_tdata     LED levels and status
// cfg       in         cfg_we cfg_index cfg_wdata    one period register write
//
// one request per cycle sustained while m_tready takes each result; a request
// passes the input register, then the state update into the result register
// all channels update in parallel in one pass
// arst_n clears all channel, vote and pair state and loads the period defaults
// a stalled result holds the result register; the input register keeps taking
// requests as long as it can move on into the result register
module led_channel_blink_controller_unit #(
	parameter int CHANNELS    = 4,
	parameter int ERROR_KINDS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// channel[1:0] partner[3:2] mode[5:4] duration_ms[37:6] error_type[38], zero fill
	input  logic [39:0] s_tdata,
	// action[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// led_levels[3:0] alternate_active[4] channel_error[6:5], zero fill
	output logic [7:0]  m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	import lcb_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	logic    out_valid_q;
	result_t res_next;
	logic    advance;
	logic    go;

	assign advance  = !out_valid_q || m_tready;
	assign go       = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, res_q.channel_error, res_q.alternate_active, res_q.led_levels};

	// period registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fast_half <= FAST_RESET;
			cfg_q.slow_half <= SLOW_RESET;
			cfg_q.on_check  <= ON_RESET;
			cfg_q.alt_half  <= ALT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FAST:   cfg_q.fast_half <= cfg_wdata;
				CFG_SLOW:   cfg_q.slow_half <= cfg_wdata;
				CFG_ON_CHK: cfg_q.on_check  <= cfg_wdata;
				CFG_ALT:    cfg_q.alt_half  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.action      <= action_t'(s_tuser);
			item_s1.channel     <= s_tdata[1:0];
			item_s1.partner     <= s_tdata[3:2];
			item_s1.mode        <= s_tdata[5:4];
			item_s1.duration_ms <= s_tdata[37:6];
			item_s1.error_type  <= s_tdata[38];
		end
	end

	lcb_core #(
		.CHANNELS    (CHANNELS),
		.ERROR_KINDS (ERROR_KINDS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (res_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_q <= res_next;
		end
	end

endmodule
